// ===== design/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int PHASE_CNT_W   = 10;
    localparam int PHASE_IDX_W   = 5;

    localparam logic [PHASE_CNT_W-1:0] PHASE_CYCLES_RESET = 10'd5;

    // phase numbers that end a section of a run
    localparam logic [PHASE_IDX_W-1:0] WR_BIT_PHASES = PHASE_IDX_W'(3 * BITS_PER_BYTE);
    localparam logic [PHASE_IDX_W-1:0] RD_LAST_PHASE = PHASE_IDX_W'(2 * BITS_PER_BYTE + 1);

    // command opcodes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_ACK   = 3'd4;

    typedef enum logic [4:0] {
        K_START = 5'b00001,
        K_STOP  = 5'b00010,
        K_WRITE = 5'b00100,
        K_READ  = 5'b01000,
        K_ACK   = 5'b10000
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] write_data;
        logic       master_nack;
        logic [7:0] slave_read_bits;
        logic       slave_ack_level;
    } t_in_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       ack_ok;
        logic [7:0] read_data;
        logic       last_phase;
    } t_out_req;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] write_data;
        logic       master_nack;
        logic [7:0] read_bits;
        logic       ack_level;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/i2cm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_front
// Accepts command requests, decodes the opcode and drops unused codes.
// ---------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in_req i_in_data,
    output logic         o_push,
    output t_cmd         o_cmd,
    input  wire logic    i_q_full
);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic dec_ok;
    t_cmd dec_cmd;

    always_comb begin
        dec_ok              = 1'b1;
        dec_cmd.kind        = K_START;
        dec_cmd.write_data  = i_in_data.write_data;
        dec_cmd.master_nack = i_in_data.master_nack;
        dec_cmd.read_bits   = i_in_data.slave_read_bits;
        dec_cmd.ack_level   = i_in_data.slave_ack_level;
        case (i_in_data.opcode)
            OP_START: dec_cmd.kind = K_START;
            OP_STOP:  dec_cmd.kind = K_STOP;
            OP_WRITE: dec_cmd.kind = K_WRITE;
            OP_READ:  dec_cmd.kind = K_READ;
            OP_ACK:   dec_cmd.kind = K_ACK;
            default:  dec_ok = 1'b0;
        endcase
    end

    assign o_in_stall = r_valid && i_q_full;
    assign o_push     = r_valid && !i_q_full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            n_valid = dec_ok;
            n_cmd   = dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

// ===== design/i2cm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_queue
// Short command queue between decoder and bus sequencer.
// ---------------------------------------------------------------------------
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/i2cm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2cm_back
// Bus phase sequencer: steps through a command's phases, holds each phase
// for at least the programmed cycle count and registers one result per phase.
// ---------------------------------------------------------------------------
module i2cm_back
    import i2cm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_valid,
    output logic                        o_cmd_pop,
    input  wire t_cmd                   i_cmd,
    input  wire logic [PHASE_CNT_W-1:0] i_phase_cycles,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out_req                    o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [PHASE_IDX_W-1:0] r_phase, n_phase;
    logic [1:0]             r_sub, n_sub;
    logic [7:0]             r_shift, n_shift;
    logic [7:0]             r_rbits, n_rbits;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic [PHASE_CNT_W-1:0] r_hold, n_hold;
    logic                   r_out_valid, n_out_valid;
    t_out_req               r_out, n_out;

    logic       out_free, emit;
    logic       ph_scl, ph_sda, ph_last, ph_ack;
    logic [7:0] ph_data, ph_shift, ph_rbits;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = (r_state == S_RUN) && (r_hold == '0) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // line levels and flags of the current phase
    always_comb begin
        ph_scl   = r_scl;
        ph_sda   = r_sda;
        ph_last  = 1'b0;
        ph_ack   = 1'b0;
        ph_data  = 8'd0;
        ph_shift = r_shift;
        ph_rbits = r_rbits;
        case (r_cmd.kind)
            K_START: begin
                if (r_phase == 5'd0) begin
                    ph_sda = 1'b1;
                end else if (r_phase == 5'd1) begin
                    ph_scl = 1'b1;
                end else if (r_phase == 5'd2) begin
                    ph_sda = 1'b0;
                end else begin
                    ph_scl  = 1'b0;
                    ph_last = 1'b1;
                end
            end
            K_STOP: begin
                if (r_phase == 5'd0) begin
                    ph_sda = 1'b0;
                end else if (r_phase == 5'd1) begin
                    ph_scl = 1'b1;
                end else begin
                    ph_sda  = 1'b1;
                    ph_last = 1'b1;
                end
            end
            K_WRITE: begin
                if (r_phase < WR_BIT_PHASES) begin
                    case (r_sub)
                        2'd0: begin
                            ph_sda   = r_shift[BITS_PER_BYTE-1];
                            ph_shift = {r_shift[BITS_PER_BYTE-2:0], 1'b0};
                        end
                        2'd1:    ph_scl = 1'b1;
                        default: ph_scl = 1'b0;
                    endcase
                end else if (r_phase == WR_BIT_PHASES) begin
                    ph_sda = 1'b1;
                end else if (r_phase == WR_BIT_PHASES + 1'b1) begin
                    ph_scl = 1'b1;
                end else begin
                    ph_scl  = 1'b0;
                    ph_last = 1'b1;
                    ph_ack  = !r_cmd.ack_level;
                end
            end
            K_READ: begin
                if (r_phase == 5'd0) begin
                    ph_sda   = 1'b1;
                    ph_shift = 8'd0;
                end else if (r_phase == RD_LAST_PHASE) begin
                    ph_scl  = 1'b0;
                    ph_last = 1'b1;
                    ph_data = r_shift;
                end else if (r_phase[0]) begin
                    ph_scl = 1'b0;
                end else begin
                    ph_scl   = 1'b1;
                    ph_shift = {r_shift[BITS_PER_BYTE-2:0], r_rbits[BITS_PER_BYTE-1]};
                    ph_rbits = {r_rbits[BITS_PER_BYTE-2:0], 1'b0};
                end
            end
            K_ACK: begin
                if (r_phase == 5'd0) begin
                    ph_sda = r_cmd.master_nack;
                end else if (r_phase == 5'd1) begin
                    ph_scl = 1'b1;
                end else begin
                    ph_scl  = 1'b0;
                    ph_last = 1'b1;
                end
            end
            default: ph_last = 1'b1;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_phase     = r_phase;
        n_sub       = r_sub;
        n_shift     = r_shift;
        n_rbits     = r_rbits;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_hold      = r_hold;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;

        if (r_hold != '0) begin
            n_hold = r_hold - 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_phase   = '0;
                    n_sub     = 2'd0;
                    n_rbits   = i_cmd.read_bits;
                    if (i_cmd.kind == K_WRITE) begin
                        n_shift = i_cmd.write_data;
                    end
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (emit) begin
                    n_out.scl_level  = ph_scl;
                    n_out.sda_drive  = ph_sda;
                    n_out.ack_ok     = ph_ack;
                    n_out.read_data  = ph_data;
                    n_out.last_phase = ph_last;
                    n_out_valid      = 1'b1;
                    n_scl            = ph_scl;
                    n_sda            = ph_sda;
                    n_shift          = ph_shift;
                    n_rbits          = ph_rbits;
                    n_sub            = (r_sub == 2'd2) ? 2'd0 : r_sub + 1'b1;
                    n_phase          = ph_last ? '0 : r_phase + 1'b1;
                    n_hold           = (i_phase_cycles == '0) ? '0 : i_phase_cycles - 1'b1;
                    if (ph_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_sub       <= 2'd0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_shift     <= n_shift;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
        end
        r_cmd   <= n_cmd;
        r_rbits <= n_rbits;
        r_out   <= n_out;
    end

endmodule
`default_nettype wire

// ===== design/i2c_master_byte_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// i2c_master_byte_engine_core
// I2C bus master running one bus command per request and returning one
// result request per bus phase (line levels, acknowledge, read byte).
// ---------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------
//  in       | input     | i_in_valid/stall  | i_in_data  (t_in_req)
//  out      | output    | o_out_valid/stall | o_out_data (t_out_req)
//  cfg      | input     | i_cfg_valid/ready | i_cfg_data (phase_cycles)
//
//  Each of a command's 3 to 27 bus phases is held for the programmed phase
//  length (0 acts as 1); the next command is fetched inside the last phase's
//  hold, which hides the fetch unless phase_cycles is 0 or 1.
//  Reset (synchronous, active low) releases both lines, empties the queue and
//  loads phase_cycles with 5. A result stall keeps the sequencer from leaving
//  its current phase; the decoder and queue keep taking requests until full.
// ---------------------------------------------------------------------------
module i2c_master_byte_engine_core
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire t_in_req                i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output t_out_req                    o_out_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [PHASE_CNT_W-1:0] i_cfg_data
);

    logic [PHASE_CNT_W-1:0] r_phase_cycles;
    logic                   push, q_full, q_valid, q_pop;
    t_cmd                   front_cmd, q_cmd;

    // configuration: always take the write, hold the phase length
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_cycles <= PHASE_CYCLES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_phase_cycles <= i_cfg_data;
        end
    end

    // decode and drop unused opcodes
    i2cm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_q_full   (q_full)
    );

    // decouple decoder from the bus sequencer
    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    // advance through bus phases, one result request per phase
    i2cm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_pop      (q_pop),
        .i_cmd          (q_cmd),
        .i_phase_cycles (r_phase_cycles),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule
`default_nettype wire
